// ===== hw/rtl/arf_pkg.sv =====
// Shared types, constants and helpers for the anchor range filter.
`timescale 1ns / 1ps
package arf_pkg;

  localparam int ANCHOR_COUNT = 4;
  localparam int ANCHOR_W     = 2;
  localparam int RANGE_W      = 16;
  localparam int WEIGHT_W     = 9;
  localparam int WIN_W        = 18;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int MIN_FILL     = 3;

  localparam logic [15:0] ADDR_BASE = 16'h0084;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

  localparam logic [1:0] KIND_RANGE    = 2'd0;
  localparam logic [1:0] KIND_CONNECT  = 2'd1;
  localparam logic [1:0] KIND_INACTIVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_JUMP    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS2     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS3     = 3'd7;

  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_INVALID,
    OP_CONNECT,
    OP_INACTIVE,
    OP_RANGE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ANCHOR_W-1:0] anchor;
    logic [RANGE_W-1:0]  sample;
  } cmd_t;

  typedef struct packed {
    logic [RANGE_W-1:0]                   min_range;
    logic [RANGE_W-1:0]                   max_range;
    logic [RANGE_W-1:0]                   max_jump;
    logic [WEIGHT_W-1:0]                  weight;
    logic [ANCHOR_COUNT-1:0][RANGE_W-1:0] bias;
  } cfg_t;

  typedef struct packed {
    logic [ANCHOR_W-1:0] anchor;
    logic [1:0]          status;
    logic [RANGE_W-1:0]  range;
    logic                valid;
  } res_t;

  function automatic logic in_window(logic signed [WIN_W-1:0] v,
                                     logic [RANGE_W-1:0] lo,
                                     logic [RANGE_W-1:0] hi);
    return (v >= $signed({2'b00, lo})) && (v <= $signed({2'b00, hi}));
  endfunction

endpackage

// ===== hw/rtl/arf_front.sv =====
// Front end: decodes the anchor address and screens raw and corrected ranges.
`timescale 1ns / 1ps
module arf_front (
  input  logic [1:0]     in_kind,
  input  logic [15:0]    in_anchor_address,
  input  logic [15:0]    in_raw_range_mm,
  input  logic           in_raw_range_ok,
  input  arf_pkg::cfg_t  cfg,
  output arf_pkg::cmd_t  cmd
);
  import arf_pkg::*;

  logic                    addr_hit;
  logic [ANCHOR_W-1:0]     anchor;
  logic signed [WIN_W-1:0] raw_ext;
  logic signed [WIN_W-1:0] bias_ext;
  logic signed [WIN_W-1:0] corr;

  assign addr_hit = (in_anchor_address[15:2] == ADDR_BASE[15:2]);
  assign anchor   = in_anchor_address[1:0];
  assign raw_ext  = $signed({2'b00, in_raw_range_mm});
  assign bias_ext = $signed({{2{cfg.bias[anchor][RANGE_W-1]}}, cfg.bias[anchor]});
  assign corr     = raw_ext - bias_ext;

  always_comb begin
    cmd.anchor = anchor;
    cmd.sample = corr[RANGE_W-1:0];
    cmd.op     = OP_IGNORE;
    if (addr_hit) begin
      case (in_kind)
        KIND_RANGE: begin
          if (!in_raw_range_ok || !in_window(raw_ext, cfg.min_range, cfg.max_range) ||
              !in_window(corr, cfg.min_range, cfg.max_range)) begin
            cmd.op = OP_INVALID;
          end else begin
            cmd.op = OP_RANGE;
          end
        end
        KIND_CONNECT:  cmd.op = OP_CONNECT;
        KIND_INACTIVE: cmd.op = OP_INACTIVE;
        default:       cmd.op = OP_IGNORE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/arf_queue.sv =====
// Short command queue between the front end and the filter engine.
`timescale 1ns / 1ps
module arf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  arf_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output arf_pkg::cmd_t pop_data
);
  import arf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/arf_back.sv =====
// Filter engine: sample rings, median selection, jump test and smoothing.
`timescale 1ns / 1ps
module arf_back #(
  parameter int MEDIAN_LENGTH = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  arf_pkg::cmd_t cmd,
  input  arf_pkg::cfg_t cfg,
  output logic          res_valid,
  input  logic          res_ready,
  output arf_pkg::res_t res
);
  import arf_pkg::*;

  localparam int IDX_W   = $clog2(MEDIAN_LENGTH);
  localparam int CNT_W   = $clog2(MEDIAN_LENGTH + 1);
  localparam int DEPTH   = ANCHOR_COUNT * MEDIAN_LENGTH;
  localparam int MADDR_W = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_SELECT = 6'b001000,
    S_DECIDE = 6'b010000,
    S_SMOOTH = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ANCHOR_W-1:0] anc_r, anc_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [RANGE_W-1:0]  med_r, med_nxt;
  logic signed [16:0]  diff_r, diff_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [RANGE_W-1:0]  t_r [MEDIAN_LENGTH];

  logic [RANGE_W-1:0]  ring_mem [DEPTH];
  logic [RANGE_W-1:0]  mem_q_r;
  logic                mem_we;
  logic [MADDR_W-1:0]  mem_waddr;
  logic [MADDR_W-1:0]  mem_raddr;

  logic [IDX_W-1:0]    wp_r       [ANCHOR_COUNT];
  logic [CNT_W-1:0]    fill_r     [ANCHOR_COUNT];
  logic                last_vld_r [ANCHOR_COUNT];
  logic [RANGE_W-1:0]  last_val_r [ANCHOR_COUNT];
  logic                sm_vld_r   [ANCHOR_COUNT];
  logic [RANGE_W-1:0]  sm_val_r   [ANCHOR_COUNT];

  logic                res_vld_r;
  res_t                res_r, res_nxt;
  logic                res_load;

  logic [ANCHOR_W-1:0] cur_anc;
  logic                clr, ring_upd, last_set, sm_set;
  logic [RANGE_W-1:0]  sm_set_val;
  logic [IDX_W-1:0]    wp_new;
  logic [CNT_W-1:0]    fill_new;
  logic                out_free;

  logic [RANGE_W-1:0]  cand;
  logic [CNT_W-1:0]    less_cnt, leq_cnt, half;
  logic [RANGE_W-1:0]  jump_abs;
  logic [WEIGHT_W-1:0] w_eff;
  logic signed [26:0]  prod, rnd, step;

  assign cur_anc   = (state_r == S_IDLE) ? cmd.anchor : anc_r;
  assign out_free  = !res_vld_r || res_ready;
  assign res_valid = res_vld_r;
  assign res       = res_r;
  assign wp_new    = (wp_r[cur_anc] == IDX_W'(MEDIAN_LENGTH - 1)) ? '0 : wp_r[cur_anc] + 1'b1;
  assign fill_new  = (fill_r[cur_anc] < CNT_W'(MEDIAN_LENGTH)) ?
                     fill_r[cur_anc] + 1'b1 : fill_r[cur_anc];
  assign mem_waddr = MADDR_W'(MADDR_W'(cmd.anchor) * MADDR_W'(MEDIAN_LENGTH)) +
                     MADDR_W'(wp_r[cmd.anchor]);
  assign mem_raddr = MADDR_W'(MADDR_W'(anc_r) * MADDR_W'(MEDIAN_LENGTH)) + MADDR_W'(cnt_r);

  assign cand = t_r[cnt_r];
  assign half = n_r >> 1;
  always_comb begin
    less_cnt = '0;
    leq_cnt  = '0;
    for (int k = 0; k < MEDIAN_LENGTH; k++) begin
      if (CNT_W'(k) < n_r) begin
        if (t_r[k] < cand) begin
          less_cnt = less_cnt + 1'b1;
        end
        if (t_r[k] <= cand) begin
          leq_cnt = leq_cnt + 1'b1;
        end
      end
    end
  end

  assign jump_abs = (med_r >= last_val_r[anc_r]) ? med_r - last_val_r[anc_r] :
                    last_val_r[anc_r] - med_r;
  assign w_eff    = (cfg.weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg.weight;
  assign prod     = 27'($signed({1'b0, w_eff})) * 27'(diff_r);
  assign rnd      = prod + 27'sd128;
  assign step     = rnd >>> 8;

  always_comb begin
    state_nxt   = state_r;
    anc_nxt     = anc_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    med_nxt     = med_r;
    diff_nxt    = diff_r;
    rd_pend_nxt = 1'b0;
    cmd_ready   = 1'b0;
    mem_we      = 1'b0;
    clr         = 1'b0;
    ring_upd    = 1'b0;
    last_set    = 1'b0;
    sm_set      = 1'b0;
    sm_set_val  = med_r;
    res_load    = 1'b0;
    res_nxt     = res_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          anc_nxt   = cmd.anchor;
          res_load  = 1'b1;
          res_nxt   = '{anchor: cmd.anchor, status: ST_INVALID,
                        range: sm_val_r[cmd.anchor], valid: sm_vld_r[cmd.anchor]};
          case (cmd.op)
            OP_IGNORE: begin
              res_nxt = '{anchor: '0, status: ST_UNKNOWN, range: '0, valid: 1'b0};
            end
            OP_CONNECT, OP_INACTIVE: begin
              clr     = 1'b1;
              res_nxt = '{anchor: cmd.anchor,
                          status: (cmd.op == OP_CONNECT) ? ST_OK : ST_INVALID,
                          range: '0, valid: 1'b0};
            end
            OP_RANGE: begin
              res_load = 1'b0;
              mem_we   = 1'b1;
              ring_upd = 1'b1;
              n_nxt    = fill_new;
              cnt_nxt  = '0;
              if (fill_new >= CNT_W'(MIN_FILL)) begin
                state_nxt = S_LOAD;
              end else begin
                med_nxt   = cmd.sample;
                state_nxt = S_DECIDE;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        rd_pend_nxt = 1'b1;
        if (cnt_r == IDX_W'(n_r - 1'b1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_SELECT;
      end
      S_SELECT: begin
        if (less_cnt <= half && leq_cnt > half) begin
          med_nxt   = cand;
          state_nxt = S_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        res_load  = 1'b1;
        res_nxt   = '{anchor: anc_r, status: ST_INVALID,
                      range: sm_val_r[anc_r], valid: sm_vld_r[anc_r]};
        if (in_window($signed({2'b00, med_r}), cfg.min_range, cfg.max_range)) begin
          if (last_vld_r[anc_r] &&
              in_window($signed({2'b00, last_val_r[anc_r]}), cfg.min_range, cfg.max_range) &&
              jump_abs > cfg.max_jump) begin
            clr     = 1'b1;
            res_nxt = '{anchor: anc_r, status: ST_JUMP, range: '0, valid: 1'b0};
          end else begin
            last_set = 1'b1;
            if (sm_vld_r[anc_r] &&
                in_window($signed({2'b00, sm_val_r[anc_r]}), cfg.min_range, cfg.max_range)) begin
              res_load  = 1'b0;
              diff_nxt  = $signed({1'b0, med_r}) - $signed({1'b0, sm_val_r[anc_r]});
              state_nxt = S_SMOOTH;
            end else begin
              sm_set  = 1'b1;
              res_nxt = '{anchor: anc_r, status: ST_OK, range: med_r, valid: 1'b1};
            end
          end
        end
      end
      S_SMOOTH: begin
        sm_set     = 1'b1;
        sm_set_val = sm_val_r[anc_r] + step[RANGE_W-1:0];
        res_load   = 1'b1;
        res_nxt    = '{anchor: anc_r, status: ST_OK, range: sm_set_val, valid: 1'b1};
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (res_load) begin
        res_vld_r <= 1'b1;
      end else if (res_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    anc_r    <= anc_nxt;
    n_r      <= n_nxt;
    cnt_r    <= cnt_nxt;
    med_r    <= med_nxt;
    diff_r   <= diff_nxt;
    rd_idx_r <= cnt_r;
    res_r    <= res_nxt;
    if (rd_pend_r) begin
      t_r[rd_idx_r] <= mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= cmd.sample;
    end
    mem_q_r <= ring_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ANCHOR_COUNT; i++) begin
        wp_r[i]       <= '0;
        fill_r[i]     <= '0;
        last_vld_r[i] <= 1'b0;
        last_val_r[i] <= '0;
        sm_vld_r[i]   <= 1'b0;
        sm_val_r[i]   <= '0;
      end
    end else if (clr) begin
      wp_r[cur_anc]       <= '0;
      fill_r[cur_anc]     <= '0;
      last_vld_r[cur_anc] <= 1'b0;
      last_val_r[cur_anc] <= '0;
      sm_vld_r[cur_anc]   <= 1'b0;
      sm_val_r[cur_anc]   <= '0;
    end else begin
      if (ring_upd) begin
        wp_r[cur_anc]   <= wp_new;
        fill_r[cur_anc] <= fill_new;
      end
      if (last_set) begin
        last_vld_r[cur_anc] <= 1'b1;
        last_val_r[cur_anc] <= med_r;
      end
      if (sm_set) begin
        sm_vld_r[cur_anc] <= 1'b1;
        sm_val_r[cur_anc] <= sm_set_val;
      end
    end
  end

endmodule

// ===== hw/rtl/anchor_range_filter.sv =====
// Top level of the anchor range filter: configuration registers and channel wiring.
`timescale 1ns / 1ps
// Range filter for four ranging anchors at short addresses 0x84 to 0x87.
// Each input transaction carries one event: a range sample, a connect or an
// inactive notice. Every input transaction yields exactly one output
// transaction with the anchor, a status code and that anchor's smoothed range;
// ignored events report anchor 0 and status unknown. Configuration is written
// through cfg_we, cfg_index and cfg_wdata while the block is idle, a rule the
// user must keep as the block does not enforce it; a write takes effect at the
// next clock edge. An input transaction enters a two-entry command queue after
// address decode and window screening, so inputs keep being taken while the
// engine works. Connect, inactive, ignored and rejected events are handled in
// the idle state, which registers their result. A range sample with fewer than
// three in its ring goes from idle to decide, and on to smooth when it updates
// an existing average; otherwise the engine reads the ring one entry per cycle
// in load and drain and tests one median candidate per cycle in select before
// decide. Results wait in an output register; while the receiver stalls, the
// engine stops at its next event and the queue fills, then in_ready drops.
// Synchronous reset restores the register defaults and empties all rings.
module anchor_range_filter #(
  parameter int MEDIAN_LENGTH = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_anchor_address,
  input  logic [15:0] in_raw_range_mm,
  input  logic        in_raw_range_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_anchor_index,
  output logic [1:0]  out_status,
  output logic [15:0] out_filtered_range_mm,
  output logic        out_filtered_valid,
  input  logic        cfg_we,
  input  logic [arf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import arf_pkg::*;

  cfg_t cfg_r;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  res_t res;
  logic queue_valid;
  logic queue_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range <= 16'd100;
      cfg_r.max_range <= 16'd60000;
      cfg_r.max_jump  <= 16'd1000;
      cfg_r.weight    <= 9'd77;
      cfg_r.bias      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RANGE: cfg_r.min_range <= cfg_wdata;
        CFG_MAX_RANGE: cfg_r.max_range <= cfg_wdata;
        CFG_MAX_JUMP:  cfg_r.max_jump  <= cfg_wdata;
        CFG_WEIGHT:    cfg_r.weight    <= cfg_wdata[WEIGHT_W-1:0];
        CFG_BIAS0:     cfg_r.bias[0]   <= cfg_wdata;
        CFG_BIAS1:     cfg_r.bias[1]   <= cfg_wdata;
        CFG_BIAS2:     cfg_r.bias[2]   <= cfg_wdata;
        CFG_BIAS3:     cfg_r.bias[3]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  arf_front u_front (
    .in_kind           (in_kind),
    .in_anchor_address (in_anchor_address),
    .in_raw_range_mm   (in_raw_range_mm),
    .in_raw_range_ok   (in_raw_range_ok),
    .cfg               (cfg_r),
    .cmd               (front_cmd)
  );

  arf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cmd)
  );

  arf_back #(
    .MEDIAN_LENGTH (MEDIAN_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .cfg       (cfg_r),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_anchor_index      = res.anchor;
  assign out_status            = res.status;
  assign out_filtered_range_mm = res.range;
  assign out_filtered_valid    = res.valid;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for anchor_range_filter: directed events, register sweeps, random traffic and stalls.
`timescale 1ns / 1ps
module tb;
  import arf_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int MEDIAN_LENGTH = 5;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_kind;
  logic [15:0] in_anchor_address;
  logic [15:0] in_raw_range_mm;
  logic in_raw_range_ok;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_anchor_index;
  logic [1:0] out_status;
  logic [15:0] out_filtered_range_mm;
  logic out_filtered_valid;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  anchor_range_filter #(.MEDIAN_LENGTH(MEDIAN_LENGTH)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_anchor_address(in_anchor_address),
    .in_raw_range_mm(in_raw_range_mm),
    .in_raw_range_ok(in_raw_range_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_anchor_index(out_anchor_index),
    .out_status(out_status),
    .out_filtered_range_mm(out_filtered_range_mm),
    .out_filtered_valid(out_filtered_valid),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  logic [15:0] win_lo, win_hi, jump_lim;
  logic [WEIGHT_W-1:0] ema_w;
  logic signed [15:0] anchor_bias [ANCHOR_COUNT];

  logic [15:0] ring_mm [ANCHOR_COUNT][MEDIAN_LENGTH];
  int ring_wr [ANCHOR_COUNT];
  int ring_fill [ANCHOR_COUNT];
  bit last_ok [ANCHOR_COUNT];
  int last_mm [ANCHOR_COUNT];
  bit smooth_ok [ANCHOR_COUNT];
  int smooth_mm [ANCHOR_COUNT];

  res_t predicted_results [$];
  int track_mm [ANCHOR_COUNT];
  int errors = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit hold_pending = 1'b0;
  bit hold_active = 1'b0;

  function automatic bit in_span(int v);
    return v >= int'(win_lo) && v <= int'(win_hi);
  endfunction

  function automatic void forget_anchor(int a);
    last_ok[a] = 1'b0;
    last_mm[a] = 0;
    smooth_ok[a] = 1'b0;
    smooth_mm[a] = 0;
    ring_wr[a] = 0;
    ring_fill[a] = 0;
  endfunction

  function automatic void reset_filter_state();
    win_lo = 16'd100;
    win_hi = 16'd60000;
    jump_lim = 16'd1000;
    ema_w = 9'd77;
    for (int a = 0; a < ANCHOR_COUNT; a++) begin
      anchor_bias[a] = '0;
      forget_anchor(a);
      track_mm[a] = 5000;
    end
  endfunction

  function automatic int median_of_ring(int a);
    int t [MEDIAN_LENGTH];
    int n, i, j, v;
    n = ring_fill[a];
    for (i = 0; i < n; i++) t[i] = int'(ring_mm[a][i]);
    for (i = 1; i < n; i++) begin
      v = t[i];
      j = i;
      while (j > 0 && t[j-1] > v) begin
        t[j] = t[j-1];
        j--;
      end
      t[j] = v;
    end
    return t[n/2];
  endfunction

  function automatic int ema_next(int prev, int x);
    int w, prod, step;
    w = (ema_w > WEIGHT_FULL) ? 256 : int'(ema_w);
    prod = w * (x - prev) + 128 + 256 * 65536;
    step = (prod >>> 8) - 65536;
    return (prev + step) & 32'hFFFF;
  endfunction

  function automatic logic [1:0] range_sample(int a, int raw, bit ok);
    int corr, med, d;
    if (!ok || !in_span(raw)) return ST_INVALID;
    corr = raw - int'(anchor_bias[a]);
    if (!in_span(corr)) return ST_INVALID;
    ring_mm[a][ring_wr[a]] = corr[15:0];
    ring_wr[a] = (ring_wr[a] + 1 >= MEDIAN_LENGTH) ? 0 : ring_wr[a] + 1;
    if (ring_fill[a] < MEDIAN_LENGTH) ring_fill[a]++;
    med = (ring_fill[a] >= MIN_FILL) ? median_of_ring(a) : corr;
    if (!in_span(med)) return ST_INVALID;
    if (last_ok[a] && in_span(last_mm[a])) begin
      d = med - last_mm[a];
      if (d < 0) d = -d;
      if (d > int'(jump_lim)) begin
        forget_anchor(a);
        return ST_JUMP;
      end
    end
    last_ok[a] = 1'b1;
    last_mm[a] = med;
    if (smooth_ok[a] && in_span(smooth_mm[a])) smooth_mm[a] = ema_next(smooth_mm[a], med);
    else smooth_mm[a] = med;
    smooth_ok[a] = 1'b1;
    return ST_OK;
  endfunction

  function automatic res_t predict_event(logic [1:0] kind, logic [15:0] addr,
                                         logic [15:0] raw, logic ok);
    res_t r;
    int a;
    r = '0;
    if (kind == KIND_UNUSED || addr < ADDR_BASE || addr > ADDR_BASE + 3) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    a = int'(addr - ADDR_BASE);
    if (kind == KIND_RANGE) begin
      r.status = range_sample(a, int'(raw), ok);
    end else begin
      forget_anchor(a);
      r.status = (kind == KIND_CONNECT) ? ST_OK : ST_INVALID;
    end
    r.anchor = a[1:0];
    r.range = smooth_mm[a][15:0];
    r.valid = smooth_ok[a];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_event(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [15:0] raw, input logic ok);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_anchor_address <= addr;
    in_raw_range_mm <= raw;
    in_raw_range_ok <= ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_results.push_back(predict_event(kind, addr, raw, ok));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_MIN_RANGE: win_lo = data;
      CFG_MAX_RANGE: win_hi = data;
      CFG_MAX_JUMP:  jump_lim = data;
      CFG_WEIGHT:    ema_w = data[WEIGHT_W-1:0];
      CFG_BIAS0:     anchor_bias[0] = data;
      CFG_BIAS1:     anchor_bias[1] = data;
      CFG_BIAS2:     anchor_bias[2] = data;
      CFG_BIAS3:     anchor_bias[3] = data;
      default: ;
    endcase
  endtask

  task automatic program_filter(input int lo, input int hi, input int jump, input int weight,
                                input int b0, input int b1, input int b2, input int b3);
    wait_for_results();
    cfg_write(CFG_MIN_RANGE, 16'(lo));
    cfg_write(CFG_MAX_RANGE, 16'(hi));
    cfg_write(CFG_MAX_JUMP, 16'(jump));
    cfg_write(CFG_WEIGHT, 16'(weight));
    cfg_write(CFG_BIAS0, 16'(b0));
    cfg_write(CFG_BIAS1, 16'(b1));
    cfg_write(CFG_BIAS2, 16'(b2));
    cfg_write(CFG_BIAS3, 16'(b3));
    cfg_we <= 1'b0;
    @(posedge clk);
    for (int a = 0; a < ANCHOR_COUNT; a++) begin
      if (win_lo <= win_hi) track_mm[a] = $urandom_range(win_lo, win_hi);
      else track_mm[a] = $urandom_range(0, 65535);
    end
  endtask

  task automatic send_random_event();
    int pick, a, span, c, raw;
    pick = $urandom_range(0, 99);
    a = $urandom_range(0, ANCHOR_COUNT - 1);
    if (pick < 70 && win_lo <= win_hi) begin
      span = (jump_lim > 3000) ? 3000 : int'(jump_lim);
      if ($urandom_range(0, 19) == 0) span = 20000;
      c = track_mm[a] + int'($urandom_range(0, 2 * span)) - span;
      if (c < int'(win_lo)) c = int'(win_lo);
      if (c > int'(win_hi)) c = int'(win_hi);
      track_mm[a] = c;
      raw = c + int'(anchor_bias[a]);
      if (raw < 0) raw = 0;
      if (raw > 65535) raw = 65535;
      send_event(KIND_RANGE, 16'(ADDR_BASE + a), 16'(raw), 1'b1);
    end else if (pick < 78) begin
      send_event($urandom_range(0, 1) ? KIND_CONNECT : KIND_INACTIVE, 16'(ADDR_BASE + a),
                 16'($urandom), 1'($urandom));
    end else if (pick < 88) begin
      send_event(KIND_RANGE, 16'(ADDR_BASE + a), 16'($urandom), 1'($urandom));
    end else if (pick < 95) begin
      send_event(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end else if ($urandom_range(0, 1) == 0) begin
      send_event(KIND_UNUSED, 16'(ADDR_BASE + a), 16'($urandom), 1'($urandom));
    end else begin
      send_event(KIND_RANGE, $urandom_range(0, 1) ? 16'(ADDR_BASE - 1) : 16'(ADDR_BASE + 4),
                 16'($urandom_range(100, 60000)), 1'b1);
    end
  endtask

  task automatic send_batch(input int count);
    for (int k = 0; k < count; k++) send_random_event();
  endtask

  task automatic test_directed_events();
    send_event(KIND_CONNECT, ADDR_BASE, 16'd0, 1'b1);
    send_event(KIND_RANGE, ADDR_BASE, 16'd100, 1'b1);
    send_event(KIND_RANGE, ADDR_BASE, 16'd60000, 1'b1);
    send_event(KIND_RANGE, ADDR_BASE, 16'd5000, 1'b0);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd99, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd60001, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'hFFFF, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'h0000, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd5000, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd5100, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd4900, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd5050, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd5200, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd5300, 1'b1);
    send_event(KIND_RANGE, 16'h0083, 16'd5000, 1'b1);
    send_event(KIND_RANGE, 16'h0088, 16'd5000, 1'b1);
    send_event(KIND_CONNECT, 16'h0000, 16'd5000, 1'b1);
    send_event(KIND_INACTIVE, 16'hFFFF, 16'd5000, 1'b1);
    send_event(KIND_UNUSED, 16'(ADDR_BASE + 2), 16'd5000, 1'b1);
    send_event(KIND_INACTIVE, 16'(ADDR_BASE + 1), 16'd0, 1'b0);
    send_event(KIND_CONNECT, 16'(ADDR_BASE + 3), 16'd0, 1'b0);
    send_event(KIND_INACTIVE, 16'(ADDR_BASE + 2), 16'd0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_bias_and_stale_window();
    program_filter(100, 60000, 1000, 77, 0, 32767, 500, -32768);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 2), 16'd550, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 2), 16'd1500, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 3), 16'd40000, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 3), 16'd20000, 1'b1);
    send_event(KIND_RANGE, 16'(ADDR_BASE + 1), 16'd40000, 1'b1);
    send_event(KIND_CONNECT, ADDR_BASE, 16'd0, 1'b1);
    send_event(KIND_RANGE, ADDR_BASE, 16'd1000, 1'b1);
    send_event(KIND_RANGE, ADDR_BASE, 16'd1010, 1'b1);
    send_event(KIND_RANGE, ADDR_BASE, 16'd990, 1'b1);
    // The held median and the previous values now fall below the raised window.
    program_filter(2000, 60000, 1000, 77, 0, 32767, 500, -32768);
    repeat (3) send_event(KIND_RANGE, ADDR_BASE, 16'd2500, 1'b1);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    program_filter(0, 65535, 0, 256, 0, 0, 0, 0);
    send_event(KIND_RANGE, ADDR_BASE, 16'h0000, 1'b1);
    send_event(KIND_RANGE, ADDR_BASE, 16'hFFFF, 1'b1);
    send_batch(25);
    program_filter(0, 65535, 65535, 0, -32768, 32767, -1, 1);
    send_batch(25);
    program_filter(0, 65535, 500, 511, 200, -200, 0, 1000);
    send_batch(25);
    program_filter(60000, 100, 1000, 77, 0, 0, 0, 0);
    send_batch(25);
    program_filter(5000, 5000, 0, 1, 0, 0, 0, 0);
    send_batch(25);
    program_filter(65535, 65535, 65535, 128, 0, 0, 0, 0);
    send_batch(25);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 5; seg++) begin
      if ($urandom_range(0, 4) == 0)
        program_filter($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 511),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        program_filter($urandom_range(0, 3000), $urandom_range(20000, 65535),
                       $urandom_range(50, 5000), $urandom_range(1, 256),
                       int'($urandom_range(0, 1000)) - 500, int'($urandom_range(0, 1000)) - 500,
                       int'($urandom_range(0, 1000)) - 500, int'($urandom_range(0, 1000)) - 500);
      for (int blk = 0; blk < 3; blk++) begin
        steady = ($urandom_range(0, 3) == 0);
        send_batch(25);
      end
      steady = 1'b0;
    end
    wait_for_results();
  endtask

  task automatic test_output_stall();
    hold_pending = 1'b1;
    while (!hold_active) @(posedge clk);
    steady = 1'b1;
    send_batch(16);
    steady = 1'b0;
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    send_batch(20);
    wait_for_results();
    send_batch(20);
    wait_for_results();
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Each output transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d", $time,
                 out_anchor_index, out_status, out_filtered_range_mm, out_filtered_valid);
      end else begin
        want = predicted_results.pop_front();
        if (out_anchor_index !== want.anchor) note_mismatch("anchor_index", int'(want.anchor),
                                                            int'(out_anchor_index));
        if (out_status !== want.status) note_mismatch("status", int'(want.status),
                                                      int'(out_status));
        if (out_filtered_range_mm !== want.range) note_mismatch("filtered_range_mm",
                                                                int'(want.range),
                                                                int'(out_filtered_range_mm));
        if (out_filtered_valid !== want.valid) note_mismatch("filtered_valid", int'(want.valid),
                                                             int'(out_filtered_valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = 1 + pick_gap();
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_RANGE;
    in_anchor_address <= '0;
    in_raw_range_mm <= '0;
    in_raw_range_ok <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MIN_RANGE;
    cfg_wdata <= '0;
    reset_filter_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_bias_and_stale_window();
    test_register_extremes();
    test_random_traffic();
    test_output_stall();
    test_sender_pause();
    wait_for_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== anchor_range_filter.f =====
hw/rtl/arf_pkg.sv
hw/rtl/arf_front.sv
hw/rtl/arf_queue.sv
hw/rtl/arf_back.sv
hw/rtl/anchor_range_filter.sv
tb/tb.sv
